// ===== design/fpm_pkg.sv =====
// fpm_pkg: shared constants, state codes and controller/datapath command types
// for the polynomial multiplier; no dependencies
`default_nettype none
package fpm_pkg;
    localparam int MAX_TERMS  = 32;
    localparam int TERM_BITS  = $clog2(MAX_TERMS);
    localparam int CNT_BITS   = TERM_BITS + 1;
    localparam int COEF_BITS  = 8;
    localparam int PROD_BITS  = 21;
    localparam logic SEL_A    = 1'b0;
    localparam logic SEL_B    = 1'b1;

    typedef enum logic [6:0] {
        ST_IDLE  = 7'b0000001,
        ST_START = 7'b0000010,
        ST_RD    = 7'b0000100,
        ST_MUL   = 7'b0001000,
        ST_ACC   = 7'b0010000,
        ST_OUT   = 7'b0100000,
        ST_EMPTY = 7'b1000000
    } fpm_state_t;

    typedef struct packed {
        logic load;
        logic clear;
        logic init_k;
        logic mul;
        logic acc;
        logic step_i;
        logic next_k;
    } fpm_cmd_t;

    typedef struct packed {
        logic a_empty;
        logic i_last;
        logic k_last;
    } fpm_status_t;
endpackage
`default_nettype wire

// ===== design/fpm_datapath.sv =====
// fpm_datapath: coefficient stores, index counters and multiply-accumulate unit
// depends on fpm_pkg
`default_nettype none
module fpm_datapath import fpm_pkg::*; (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire fpm_cmd_t             cmd,
    input  wire logic                 sel,
    input  wire logic [COEF_BITS-1:0] coef,
    output fpm_status_t               status,
    output logic [PROD_BITS-1:0]      acc_out
);
    logic [COEF_BITS-1:0] mem_a [MAX_TERMS];
    logic [COEF_BITS-1:0] mem_b [MAX_TERMS];
    logic [CNT_BITS-1:0]  count_a_reg, count_b_reg;
    logic [CNT_BITS-1:0]  k_reg;
    logic [TERM_BITS-1:0] i_reg;
    logic [COEF_BITS-1:0] rd_a_reg, rd_b_reg;
    logic                 term_ok_reg;
    logic [2*COEF_BITS-1:0] prod_reg;
    logic [PROD_BITS-1:0] acc_reg;
    logic [CNT_BITS:0]    j_wide;
    logic [CNT_BITS:0]    len;
    logic                 j_ok;

    assign j_wide = {1'b0, k_reg} - {2'b0, i_reg};
    assign j_ok   = !j_wide[CNT_BITS] && (j_wide[CNT_BITS-1:0] < count_b_reg);
    assign len    = {1'b0, count_a_reg} + {1'b0, count_b_reg} - (CNT_BITS+1)'(1);

    assign status.a_empty = (count_a_reg == '0);
    assign status.i_last  = ({1'b0, i_reg} + CNT_BITS'(1)) == count_a_reg;
    assign status.k_last  = ({1'b0, k_reg} + (CNT_BITS+1)'(1)) == len;
    assign acc_out = acc_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_a_reg <= '0;
            count_b_reg <= '0;
        end else if (cmd.clear) begin
            count_a_reg <= '0;
            count_b_reg <= '0;
        end else if (cmd.load) begin
            if (sel == SEL_A && !count_a_reg[CNT_BITS-1])
                count_a_reg <= count_a_reg + CNT_BITS'(1);
            if (sel == SEL_B && !count_b_reg[CNT_BITS-1])
                count_b_reg <= count_b_reg + CNT_BITS'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load && sel == SEL_A && !count_a_reg[CNT_BITS-1])
            mem_a[count_a_reg[TERM_BITS-1:0]] <= coef;
        if (cmd.load && sel == SEL_B && !count_b_reg[CNT_BITS-1])
            mem_b[count_b_reg[TERM_BITS-1:0]] <= coef;
        rd_a_reg    <= mem_a[i_reg];
        rd_b_reg    <= mem_b[j_wide[TERM_BITS-1:0]];
        term_ok_reg <= j_ok;
    end

    always_ff @(posedge aclk) begin
        if (cmd.init_k) begin
            k_reg   <= '0;
            i_reg   <= '0;
            acc_reg <= '0;
        end else if (cmd.next_k) begin
            k_reg   <= k_reg + CNT_BITS'(1);
            i_reg   <= '0;
            acc_reg <= '0;
        end else begin
            if (cmd.step_i)
                i_reg <= i_reg + TERM_BITS'(1);
            if (cmd.acc)
                acc_reg <= acc_reg + PROD_BITS'(prod_reg);
        end
        if (cmd.mul)
            prod_reg <= term_ok_reg ? rd_a_reg * rd_b_reg : '0;
    end
endmodule
`default_nettype wire

// ===== design/fpm_ctrl.sv =====
// fpm_ctrl: sequencer for load, multiply-accumulate and result request phases
// depends on fpm_pkg
`default_nettype none
module fpm_ctrl import fpm_pkg::*; (
    input  wire logic   aclk,
    input  wire logic   aresetn,
    input  wire logic   s_valid,
    input  wire logic   s_req_type,
    input  wire logic   s_last,
    output logic        s_ready,
    output logic        m_valid,
    input  wire logic   m_ready,
    output logic        m_last_res,
    input  wire fpm_status_t status,
    output fpm_cmd_t    cmd
);
    fpm_state_t state_reg, state_next;
    logic s_fire, m_fire;

    assign s_ready = state_reg == ST_IDLE;
    assign m_valid = state_reg == ST_OUT || state_reg == ST_EMPTY;
    assign m_last_res = state_reg == ST_EMPTY || status.k_last;
    assign s_fire = s_valid && s_ready;
    assign m_fire = m_valid && m_ready;

    always_comb begin
        state_next = state_reg;
        cmd = '0;
        unique case (state_reg)
            ST_IDLE: begin
                cmd.load = s_fire;
                if (s_fire && s_req_type == SEL_B && s_last)
                    state_next = ST_START;
            end
            ST_START: begin
                cmd.init_k = 1'b1;
                state_next = status.a_empty ? ST_EMPTY : ST_RD;
            end
            ST_RD:  state_next = ST_MUL;
            ST_MUL: begin
                cmd.mul = 1'b1;
                state_next = ST_ACC;
            end
            ST_ACC: begin
                cmd.acc = 1'b1;
                if (status.i_last) begin
                    state_next = ST_OUT;
                end else begin
                    cmd.step_i = 1'b1;
                    state_next = ST_RD;
                end
            end
            ST_OUT: begin
                if (m_fire) begin
                    if (status.k_last) begin
                        cmd.clear = 1'b1;
                        state_next = ST_IDLE;
                    end else begin
                        cmd.next_k = 1'b1;
                        state_next = ST_RD;
                    end
                end
            end
            ST_EMPTY: begin
                if (m_fire) begin
                    cmd.clear = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end
endmodule
`default_nettype wire

// ===== design/fft_polynomial_multiplier.sv =====
// fft_polynomial_multiplier: top level joining controller and datapath
// depends on fpm_pkg, fpm_ctrl, fpm_datapath
//
// channel | ports                               | direction
// input   | s_valid s_ready s_req_type s_coef s_last | request in
// result  | m_valid m_ready m_product_coef m_last_res | request out
//
// a coefficient request is taken while idle
// each product coefficient sums the terms of A through one shared multiplier
// fed by registered store reads: read, multiply and accumulate per term
// no input is taken while results are computed or waiting on m_ready
// reset (aresetn low, synchronous) empties both stores
`default_nettype none
module fft_polynomial_multiplier import fpm_pkg::*; (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire logic                 s_req_type,
    input  wire logic [COEF_BITS-1:0] s_coef,
    input  wire logic                 s_last,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output logic [PROD_BITS-1:0]      m_product_coef,
    output logic                      m_last_res
);
    fpm_cmd_t    cmd;
    fpm_status_t status;

    fpm_ctrl u_ctrl (
        .aclk, .aresetn, .s_valid, .s_req_type, .s_last, .s_ready,
        .m_valid, .m_ready, .m_last_res, .status, .cmd
    );

    fpm_datapath u_dp (
        .aclk, .aresetn, .cmd, .sel(s_req_type), .coef(s_coef),
        .status, .acc_out(m_product_coef)
    );
endmodule
`default_nettype wire

// ===== design/fpm_checker.sv =====
// fpm_checker: port-level assertions for the polynomial multiplier
// depends on fpm_pkg; bound to fft_polynomial_multiplier
`default_nettype none
module fpm_checker import fpm_pkg::*; (
    input wire logic                 aclk,
    input wire logic                 aresetn,
    input wire logic                 s_ready,
    input wire logic                 m_valid,
    input wire logic                 m_ready,
    input wire logic [PROD_BITS-1:0] m_product_coef,
    input wire logic                 m_last_res
);
    // load and result phases never overlap
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid)) else $error("s_ready with m_valid");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_product_coef) && $stable(m_last_res))
        else $error("result not held");

    // final result returns the block to loading
    a_back_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && m_last_res |=> s_ready && !m_valid)
        else $error("not idle after final result");

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> s_ready && !m_valid) else $error("bad state after reset");

    a_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_product_coef <= PROD_BITS'(2080800)) else $error("result out of range");
endmodule

bind fft_polynomial_multiplier fpm_checker u_chk (
    .aclk, .aresetn, .s_ready, .m_valid, .m_ready,
    .m_product_coef, .m_last_res
);
`default_nettype wire
